### rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared command codes, status codes and result flags of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DepthDefault     = 16;
  localparam int DataWidthDefault = 32;

  // Fixed widths of the stream fields.
  localparam int CMD_W    = 3;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd2;

  // Everything about a result except the data read from the store.
  typedef struct packed {
    logic                data_ok;    // store read data is the result data
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;
    logic                is_full;
  } result_meta_t;

endpackage

### rtl/core/circular_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue in a ring store, driven by a command stream.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the slave side carries one command in s_tuser
//   (push front, push rear, pop front, pop rear, peek front, peek rear,
//   clear) and the element to push in s_tdata. Every command yields exactly
//   one transaction on the master side with the data read, a status code,
//   the occupancy after the command, and the empty and full flags.
//   A command accepted at one edge has its result valid after that edge.
//   Throughput is one command per cycle while the receiver takes each result;
//   the single store port does either the write of a push or the read of a
//   pop or peek, so each command needs at most one port access.
//   Head and count update at the accepting edge, so a following command
//   sees the new state and a write is visible to the very next read.
//   When the receiver stalls, the result stays in the output stage (the
//   store read register holds its data since no new read is issued) and
//   s_tready drops until the result is taken.
//   Reset clears the head index, the entry count and the output valid. The
//   store is not cleared; only written entries can ever be read.
//   Pops and peeks on an empty deque report underflow with data 0; pushes
//   on a full deque report overflow. Neither changes the state.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int DEPTH      = cdq_pkg::DepthDefault,
  parameter int DATA_WIDTH = cdq_pkg::DataWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element_value
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] read_data, [33:32] status, [38:34] occupancy, [39] is_empty,
  // [40] is_full, [47:41] zero
  output logic [47:0] m_tdata
);

  localparam int AW = $clog2(DEPTH);

  logic                  accept;
  logic                  mem_wr_en, mem_rd_en;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  cdq_pkg::result_meta_t result_meta;
  logic [31:0]           read_data;

  // The output stage frees up in the same cycle its result is taken.
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (s_tuser),
    .element_value (s_tdata),
    .mem_wr_en     (mem_wr_en),
    .mem_rd_en     (mem_rd_en),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .result_meta   (result_meta)
  );

  cdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .wr_en (mem_wr_en),
    .rd_en (mem_rd_en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Stored entries are zero-extended to the result width; results without a
  // store read (pushes, clear, underflow, the unused code) carry zero data.
  assign read_data = result_meta.data_ok ? 32'(mem_rdata) : '0;

  assign m_tdata = {7'd0, result_meta.is_full, result_meta.is_empty,
                    result_meta.occupancy, result_meta.status, read_data};

`ifndef SYNTHESIS
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted command produced no result");
`endif

endmodule

### rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Entry store of the deque: one port, synchronous write and registered read.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int DEPTH      = cdq_pkg::DepthDefault,
  parameter int DATA_WIDTH = cdq_pkg::DataWidthDefault,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic                  rd_en,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // The read register holds its value until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head index and entry count of the deque, store addressing and result flags.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
  parameter int DEPTH      = cdq_pkg::DepthDefault,
  parameter int DATA_WIDTH = cdq_pkg::DataWidthDefault,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [cdq_pkg::CMD_W-1:0]     command,
  input  logic [cdq_pkg::ELEM_W-1:0]    element_value,
  output logic                          mem_wr_en,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_addr,
  output logic [DATA_WIDTH-1:0]         mem_wdata,
  output cdq_pkg::result_meta_t         result_meta
);

  localparam int SW = CW + 1;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  logic                  empty, full;
  logic [AW-1:0]         head_dec, head_inc, rear_free, rear_last;
  logic [SW-1:0]         free_sum, last_sum;
  logic                  wr_req, rd_req;
  logic [AW-1:0]         addr;
  logic [cdq_pkg::STATUS_W-1:0] status;

  assign empty = (count == '0);
  assign full  = (count >= CW'(DEPTH));

  // Ring arithmetic: every sum stays below twice DEPTH, so one compare and
  // subtract folds it back into range.
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign free_sum = SW'(head) + SW'(count);
  assign last_sum = SW'(head) + SW'(count) - SW'(1);
  assign rear_free = (free_sum >= SW'(DEPTH)) ? AW'(free_sum - SW'(DEPTH)) : AW'(free_sum);
  assign rear_last = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    wr_req     = 1'b0;
    rd_req     = 1'b0;
    addr       = head;
    status     = cdq_pkg::STAT_OK;
    unique case (command) inside
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = cdq_pkg::STAT_OVERFLOW;
        end else begin
          head_next  = head_dec;
          addr       = head_dec;
          wr_req     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      cdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          status = cdq_pkg::STAT_OVERFLOW;
        end else begin
          addr       = rear_free;
          wr_req     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_PEEK_FRONT: begin
        if (empty) begin
          status = cdq_pkg::STAT_UNDERFLOW;
        end else begin
          addr   = head;
          rd_req = 1'b1;
          if (command == cdq_pkg::CMD_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - CW'(1);
          end
        end
      end
      cdq_pkg::CMD_POP_REAR, cdq_pkg::CMD_PEEK_REAR: begin
        if (empty) begin
          status = cdq_pkg::STAT_UNDERFLOW;
        end else begin
          addr   = rear_last;
          rd_req = 1'b1;
          if (command == cdq_pkg::CMD_POP_REAR) begin
            count_next = count - CW'(1);
          end
        end
      end
      cdq_pkg::CMD_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_wr_en = accept & wr_req;
  assign mem_rd_en = accept & rd_req;
  assign mem_addr  = addr;
  assign mem_wdata = DATA_WIDTH'($unsigned(element_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Result flags are registered at the accepting edge, together with the store read.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_meta.data_ok   <= rd_req;
      result_meta.status    <= status;
      result_meta.occupancy <= cdq_pkg::OCC_W'(count_next);
      result_meta.is_empty  <= (count_next == '0);
      result_meta.is_full   <= (count_next >= CW'(DEPTH));
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds the store depth");

  a_head_bound : assert property (@(posedge clk) disable iff (rst)
    32'(head) < DEPTH)
    else $error("head index outside the ring");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    accept && command == cdq_pkg::CMD_CLEAR |=> count == '0 && head == '0)
    else $error("clear did not empty the deque");
`endif

endmodule

### dv/circular_deque_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_unit_test
// Self-checking testbench for the command-driven circular deque.
// ----------------------------------------------------------------------------
// A mirror of the ring store, head and count predicts every result when its
// command is accepted, and a checker compares each returned transaction with
// the oldest prediction, field by field. A short directed sequence covers
// the empty and full corners, every command and the extreme data values.
// Random traffic with a drifting push/pop balance then fills, drains and
// wraps the ring under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module circular_deque_unit_test;

  localparam int DEPTH = cdq_pkg::DepthDefault;

  // Code 7 has no command behind it; the block must answer it without
  // touching its state.
  localparam logic [cdq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  // One predicted result, in the order the fields appear on m_tdata.
  typedef struct packed {
    logic [cdq_pkg::ELEM_W-1:0]   read_data;
    logic [cdq_pkg::STATUS_W-1:0] status;
    logic [cdq_pkg::OCC_W-1:0]    occupancy;
    logic                         is_empty;
    logic                         is_full;
  } deque_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] element_value
  logic [2:0]  s_tuser  = '0;   // [2:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [31:0] read_data, [33:32] status, [38:34] occupancy, [39] is_empty,
  // [40] is_full, [47:41] zero
  logic [47:0] m_tdata;

  circular_deque_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Mirror of the deque state.
  logic [cdq_pkg::ELEM_W-1:0] mirror_store [DEPTH];
  logic [3:0]                 mirror_head;
  logic [cdq_pkg::OCC_W-1:0]  mirror_count;

  // Results predicted but not yet returned, oldest first.
  deque_result_t pending_results [$];
  deque_result_t oldest;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int errors          = 0;
  int cmds_accepted   = 0;
  int results_checked = 0;
  int underflows_seen = 0;
  int overflows_seen  = 0;
  int full_reached    = 0;
  int clears_seen     = 0;

  // Applies one command to the mirror and returns the result it must give.
  function automatic deque_result_t apply_command(logic [cdq_pkg::CMD_W-1:0] cmd,
                                                  logic [cdq_pkg::ELEM_W-1:0] value);
    deque_result_t             res;
    logic [3:0]                slot;
    logic [cdq_pkg::OCC_W-1:0] last;
    res  = '0;
    last = mirror_count - 5'd1;
    case (cmd) inside
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
        if (mirror_count == DEPTH) begin
          res.status = cdq_pkg::STAT_OVERFLOW;
          overflows_seen++;
        end else begin
          if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            // The head steps back one slot and the new entry lands there.
            mirror_head = mirror_head - 4'd1;
            slot        = mirror_head;
          end else begin
            slot = mirror_head + mirror_count[3:0];
          end
          mirror_store[slot] = value;
          mirror_count       = mirror_count + 5'd1;
          if (mirror_count == DEPTH) full_reached++;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR,
      cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_REAR: begin
        if (mirror_count == 0) begin
          res.status = cdq_pkg::STAT_UNDERFLOW;
          underflows_seen++;
        end else begin
          if (cmd == cdq_pkg::CMD_POP_FRONT || cmd == cdq_pkg::CMD_PEEK_FRONT)
            slot = mirror_head;
          else slot = mirror_head + last[3:0];
          res.read_data = mirror_store[slot];
          // Peeks leave the entry where it is.
          if (cmd == cdq_pkg::CMD_POP_FRONT) begin
            mirror_head  = mirror_head + 4'd1;
            mirror_count = last;
          end else if (cmd == cdq_pkg::CMD_POP_REAR) begin
            mirror_count = last;
          end
        end
      end
      cdq_pkg::CMD_CLEAR: begin
        mirror_head  = '0;
        mirror_count = '0;
        clears_seen++;
      end
      default: ;
    endcase
    res.occupancy = mirror_count;
    res.is_empty  = (mirror_count == 0);
    res.is_full   = (mirror_count == DEPTH);
    return res;
  endfunction

  // The data values that sit at the corners of the signed and unsigned ranges.
  function automatic logic [31:0] edge_value(int unsigned which);
    case (which % 4)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Sends one command and returns at the edge where it is accepted. The
  // valid stays high afterwards so that back-to-back commands need no gap.
  task automatic send_command(input logic [cdq_pkg::CMD_W-1:0] cmd,
                              input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 3'($urandom_range(7));
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_command(cmd, value));
    cmds_accepted++;
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random command; push_pct sets how strongly the mix tends to fill.
  function automatic logic [cdq_pkg::CMD_W-1:0] pick_command(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 1) return CMD_UNUSED;
    if (roll < 3) return cdq_pkg::CMD_CLEAR;
    if (roll < 3 + push_pct)
      return $urandom_range(1) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT;
    // Two pops for every peek, so that the store actually drains.
    case ($urandom_range(5))
      0, 1:    return cdq_pkg::CMD_POP_FRONT;
      2, 3:    return cdq_pkg::CMD_POP_REAR;
      4:       return cdq_pkg::CMD_PEEK_FRONT;
      default: return cdq_pkg::CMD_PEEK_REAR;
    endcase
  endfunction

  // Random traffic whose push share swings between filling, draining and
  // balanced stretches, so the ring wraps and hits both ends often.
  task automatic run_random_traffic(input int unsigned count);
    int unsigned push_pct;
    int unsigned stretch;
    logic [31:0] value;
    push_pct = 40;
    stretch  = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (stretch == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 70;
          1:       push_pct = 20;
          default: push_pct = 40;
        endcase
        stretch = $urandom_range(60, 24);
      end
      stretch--;
      value = ($urandom_range(7) == 0) ? edge_value($urandom_range(3)) : $urandom;
      send_command(pick_command(push_pct), value);
    end
  endtask

  // Directed corners: fill to full from both ends with the extreme values,
  // overflow at both ends, peeks, the unused code, pops, a clear of a busy
  // deque, and then underflow on every read command.
  task automatic test_empty_and_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int unsigned i = 0; i < DEPTH; i++)
      send_command((i % 2) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT,
                   (i < 8) ? edge_value(i) : $urandom);
    send_command(cdq_pkg::CMD_PEEK_FRONT, $urandom);
    send_command(cdq_pkg::CMD_PEEK_REAR, $urandom);
    send_command(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    send_command(CMD_UNUSED, $urandom);
    send_command(cdq_pkg::CMD_POP_FRONT, $urandom);
    send_command(cdq_pkg::CMD_POP_REAR, $urandom);
    send_command(cdq_pkg::CMD_CLEAR, $urandom);
    send_command(cdq_pkg::CMD_POP_FRONT, $urandom);
    send_command(cdq_pkg::CMD_POP_REAR, $urandom);
    send_command(cdq_pkg::CMD_PEEK_FRONT, $urandom);
    send_command(cdq_pkg::CMD_PEEK_REAR, $urandom);
  endtask

  // Full rate in both directions.
  task automatic test_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_traffic(460);
  endtask

  // Sparse commands with an eager receiver.
  task automatic test_sender_gaps();
    send_idle_pct  = 73;
    recv_stall_pct = 0;
    run_random_traffic(460);
  endtask

  // Heavy backpressure; the output stage must hold its result.
  task automatic test_receiver_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 73;
    run_random_traffic(460);
  endtask

  // Light idling on both sides, with a full pause midway so the block
  // restarts from a quiet state.
  task automatic test_mixed_idling();
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    run_random_traffic(240);
    wait_results_drained();
    run_random_traffic(240);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Result checker: one transaction per edge where valid meets ready.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no command waiting, expected none, got %h",
                 $time, m_tdata);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        check_field("read_data", oldest.read_data, m_tdata[31:0]);
        check_field("status", 32'(oldest.status), 32'(m_tdata[33:32]));
        check_field("occupancy", 32'(oldest.occupancy), 32'(m_tdata[38:34]));
        check_field("is_empty", 32'(oldest.is_empty), 32'(m_tdata[39]));
        check_field("is_full", 32'(oldest.is_full), 32'(m_tdata[40]));
        check_field("padding", 32'h0, 32'(m_tdata[47:41]));
      end
    end
  end

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    mirror_head  = '0;
    mirror_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_full();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idling();
    wait_results_drained();
    repeat (4) @(posedge clk);
    $display("Covered %0d commands and %0d results: %0d underflows, %0d overflows,",
             cmds_accepted, results_checked, underflows_seen, overflows_seen);
    $display("the deque filled %0d times and was cleared %0d times.",
             full_reached, clears_seen);
    if (errors == 0) begin
      $display("circular_deque_unit_test: PASS");
    end else begin
      $display("circular_deque_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", pending_results.size());
    $display("circular_deque_unit_test: FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque_unit.sv
dv/circular_deque_unit_test.sv
